FILE: design/rsi_pkg.sv
// Package: payload types and widths for the ray/segment intersection pipeline
`timescale 1ns / 1ps
package rsi_pkg;

  localparam int CW  = 32;            // coordinate width
  localparam int QW  = CW;            // quotient bits, one per divider cell
  localparam int SW  = 2 * CW + 2;    // divisor width, a + b
  localparam int NW  = 3 * CW + 3;    // signed numerator width
  localparam int DQW = 2 * CW;        // squared step length width
  localparam logic [CW-1:0] THR_RESET = CW'(429);

  typedef struct packed {
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] dir_x;
    logic signed [CW-1:0] dir_y;
    logic signed [CW-1:0] seg_p1_x;
    logic signed [CW-1:0] seg_p1_y;
    logic signed [CW-1:0] seg_p2_x;
    logic signed [CW-1:0] seg_p2_y;
  } rsi_in_t;

  typedef struct packed {
    logic                 hit;
    logic                 on_segment_line;
    logic signed [CW-1:0] int_x;
    logic signed [CW-1:0] int_y;
  } rsi_out_t;

  typedef struct packed {
    logic                 online;
    logic                 nohit;
    logic                 negx;
    logic                 negy;
    logic [SW-1:0]        s;
    logic [SW-1:0]        remx;
    logic [SW-1:0]        remy;
    logic [QW-1:0]        lox;
    logic [QW-1:0]        loy;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic [DQW-1:0]       dsq;
  } rsi_div_t;

endpackage

FILE: design/rsi_front.sv
// Front pipeline: offsets, cross products, weights, numerators and divider set-up
`timescale 1ns / 1ps
module rsi_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rsi_pkg::rsi_in_t   in_data,
  input  logic [31:0]        thr,
  output logic               dn_valid,
  output rsi_pkg::rsi_div_t  dn_data,
  input  logic               dn_adv
);
  import rsi_pkg::*;

  typedef struct packed {
    logic signed [CW-1:0] px, py, dx, dy, s1x, s1y, s2x, s2y;
    logic signed [CW:0]   v1x, v1y, v2x, v2y;
  } st1_t;

  typedef struct packed {
    logic signed [2*CW+1:0] c1, c2;
    logic signed [2*CW:0]   a1, a2, b1, b2;
    logic [DQW-1:0]         dxx, dyy;
    logic signed [CW-1:0]   px, py, s1x, s1y, s2x, s2y;
  } st2_t;

  typedef struct packed {
    logic signed [2*CW+2:0] c;
    logic signed [2*CW+1:0] a, b;
    logic [DQW-1:0]         dsq;
    logic signed [CW-1:0]   px, py, s1x, s1y, s2x, s2y;
  } st3_t;

  typedef struct packed {
    logic                 online, neg;
    logic [SW-1:0]        s;
    logic [2*CW:0]        am, bm;
    logic [DQW-1:0]       dsq;
    logic signed [CW-1:0] px, py, s1x, s1y, s2x, s2y;
  } st4_t;

  typedef struct packed {
    logic                   online, nohit;
    logic [SW-1:0]          s;
    logic [DQW-1:0]         dsq;
    logic signed [CW-1:0]   px, py;
    logic signed [2*CW+1:0] pxl, qxl, pyl, qyl;
    logic signed [2*CW:0]   pxh, qxh, pyh, qyh;
  } st5_t;

  typedef struct packed {
    logic                 online, nohit;
    logic [SW-1:0]        s;
    logic [DQW-1:0]       dsq;
    logic signed [CW-1:0] px, py;
    logic [NW-1:0]        tx, ux, ty, uy;
  } st6_t;

  typedef struct packed {
    logic                 online, nohit;
    logic [SW-1:0]        s;
    logic [DQW-1:0]       dsq;
    logic signed [CW-1:0] px, py;
    logic [NW-1:0]        nx, ny;
  } st7_t;

  logic [7:0] v_r, adv;
  st1_t s1_r, s1_nxt;
  st2_t s2_r, s2_nxt;
  st3_t s3_r, s3_nxt;
  st4_t s4_r, s4_nxt;
  st5_t s5_r, s5_nxt;
  st6_t s6_r, s6_nxt;
  st7_t s7_r, s7_nxt;
  rsi_div_t s8_r, s8_nxt;

  always_comb begin
    adv[7] = !v_r[7] || dn_adv;
    for (int k = 6; k >= 0; k--) adv[k] = !v_r[k] || adv[k+1];
  end
  assign in_stall = !adv[0];

  always_comb begin
    s1_nxt.px  = in_data.point_x;
    s1_nxt.py  = in_data.point_y;
    s1_nxt.dx  = in_data.dir_x;
    s1_nxt.dy  = in_data.dir_y;
    s1_nxt.s1x = in_data.seg_p1_x;
    s1_nxt.s1y = in_data.seg_p1_y;
    s1_nxt.s2x = in_data.seg_p2_x;
    s1_nxt.s2y = in_data.seg_p2_y;
    s1_nxt.v1x = {in_data.seg_p1_x[CW-1], in_data.seg_p1_x}
               - {in_data.point_x[CW-1], in_data.point_x};
    s1_nxt.v1y = {in_data.seg_p1_y[CW-1], in_data.seg_p1_y}
               - {in_data.point_y[CW-1], in_data.point_y};
    s1_nxt.v2x = {in_data.seg_p2_x[CW-1], in_data.seg_p2_x}
               - {in_data.point_x[CW-1], in_data.point_x};
    s1_nxt.v2y = {in_data.seg_p2_y[CW-1], in_data.seg_p2_y}
               - {in_data.point_y[CW-1], in_data.point_y};
  end

  always_comb begin
    logic signed [2*CW-1:0] sqx, sqy;
    sqx = s1_r.dx * s1_r.dx;
    sqy = s1_r.dy * s1_r.dy;
    s2_nxt.c1  = s1_r.v1x * s1_r.v2y;
    s2_nxt.c2  = s1_r.v1y * s1_r.v2x;
    s2_nxt.a1  = s1_r.v1x * s1_r.dy;
    s2_nxt.a2  = s1_r.v1y * s1_r.dx;
    s2_nxt.b1  = s1_r.v2y * s1_r.dx;
    s2_nxt.b2  = s1_r.v2x * s1_r.dy;
    s2_nxt.dxx = sqx;
    s2_nxt.dyy = sqy;
    s2_nxt.px  = s1_r.px;
    s2_nxt.py  = s1_r.py;
    s2_nxt.s1x = s1_r.s1x;
    s2_nxt.s1y = s1_r.s1y;
    s2_nxt.s2x = s1_r.s2x;
    s2_nxt.s2y = s1_r.s2y;
  end

  always_comb begin
    s3_nxt.c   = {s2_r.c1[2*CW+1], s2_r.c1} - {s2_r.c2[2*CW+1], s2_r.c2};
    s3_nxt.a   = {s2_r.a1[2*CW], s2_r.a1} - {s2_r.a2[2*CW], s2_r.a2};
    // cross(d, v2) = dx*v2y - dy*v2x
    s3_nxt.b   = {s2_r.b1[2*CW], s2_r.b1} - {s2_r.b2[2*CW], s2_r.b2};
    s3_nxt.dsq = s2_r.dxx + s2_r.dyy;
    s3_nxt.px  = s2_r.px;
    s3_nxt.py  = s2_r.py;
    s3_nxt.s1x = s2_r.s1x;
    s3_nxt.s1y = s2_r.s1y;
    s3_nxt.s2x = s2_r.s2x;
    s3_nxt.s2y = s2_r.s2y;
  end

  always_comb begin
    logic signed [2*CW+2:0] thr_s;
    thr_s = $signed({(2*CW+3-32)'(0), thr});
    s4_nxt.online = (s3_r.c < thr_s) && (s3_r.c > -thr_s);
    s4_nxt.neg    = s3_r.a[2*CW+1] || s3_r.b[2*CW+1];
    s4_nxt.am     = s3_r.a[2*CW:0];
    s4_nxt.bm     = s3_r.b[2*CW:0];
    s4_nxt.s      = {1'b0, s3_r.a[2*CW:0]} + {1'b0, s3_r.b[2*CW:0]};
    s4_nxt.dsq    = s3_r.dsq;
    s4_nxt.px     = s3_r.px;
    s4_nxt.py     = s3_r.py;
    s4_nxt.s1x    = s3_r.s1x;
    s4_nxt.s1y    = s3_r.s1y;
    s4_nxt.s2x    = s3_r.s2x;
    s4_nxt.s2y    = s3_r.s2y;
  end

  always_comb begin
    logic signed [CW+1:0] blo, alo;
    logic signed [CW:0]   bhi, ahi;
    blo = $signed({1'b0, s4_r.bm[CW:0]});
    alo = $signed({1'b0, s4_r.am[CW:0]});
    bhi = $signed({1'b0, s4_r.bm[2*CW:CW+1]});
    ahi = $signed({1'b0, s4_r.am[2*CW:CW+1]});
    s5_nxt.online = s4_r.online;
    s5_nxt.nohit  = s4_r.neg || (s4_r.s == '0);
    s5_nxt.s      = s4_r.s;
    s5_nxt.dsq    = s4_r.dsq;
    s5_nxt.px     = s4_r.px;
    s5_nxt.py     = s4_r.py;
    s5_nxt.pxl    = s4_r.s1x * blo;
    s5_nxt.pxh    = s4_r.s1x * bhi;
    s5_nxt.qxl    = s4_r.s2x * alo;
    s5_nxt.qxh    = s4_r.s2x * ahi;
    s5_nxt.pyl    = s4_r.s1y * blo;
    s5_nxt.pyh    = s4_r.s1y * bhi;
    s5_nxt.qyl    = s4_r.s2y * alo;
    s5_nxt.qyh    = s4_r.s2y * ahi;
  end

  always_comb begin
    s6_nxt.online = s5_r.online;
    s6_nxt.nohit  = s5_r.nohit;
    s6_nxt.s      = s5_r.s;
    s6_nxt.dsq    = s5_r.dsq;
    s6_nxt.px     = s5_r.px;
    s6_nxt.py     = s5_r.py;
    s6_nxt.tx = {{(NW-2*CW-2){s5_r.pxl[2*CW+1]}}, s5_r.pxl}
              + {s5_r.pxh[2*CW], s5_r.pxh, (CW+1)'(0)};
    s6_nxt.ux = {{(NW-2*CW-2){s5_r.qxl[2*CW+1]}}, s5_r.qxl}
              + {s5_r.qxh[2*CW], s5_r.qxh, (CW+1)'(0)};
    s6_nxt.ty = {{(NW-2*CW-2){s5_r.pyl[2*CW+1]}}, s5_r.pyl}
              + {s5_r.pyh[2*CW], s5_r.pyh, (CW+1)'(0)};
    s6_nxt.uy = {{(NW-2*CW-2){s5_r.qyl[2*CW+1]}}, s5_r.qyl}
              + {s5_r.qyh[2*CW], s5_r.qyh, (CW+1)'(0)};
  end

  always_comb begin
    s7_nxt.online = s6_r.online;
    s7_nxt.nohit  = s6_r.nohit;
    s7_nxt.s      = s6_r.s;
    s7_nxt.dsq    = s6_r.dsq;
    s7_nxt.px     = s6_r.px;
    s7_nxt.py     = s6_r.py;
    s7_nxt.nx     = s6_r.tx + s6_r.ux;
    s7_nxt.ny     = s6_r.ty + s6_r.uy;
  end

  // magnitude plus half divisor; quotient fits QW bits
  always_comb begin
    logic [NW-1:0] h, mx, my;
    h  = {(NW-SW)'(0), s7_r.s >> 1};
    mx = s7_r.nx[NW-1] ? (h - s7_r.nx) : (h + s7_r.nx);
    my = s7_r.ny[NW-1] ? (h - s7_r.ny) : (h + s7_r.ny);
    s8_nxt.online = s7_r.online;
    s8_nxt.nohit  = s7_r.nohit;
    s8_nxt.negx   = s7_r.nx[NW-1];
    s8_nxt.negy   = s7_r.ny[NW-1];
    s8_nxt.s      = s7_r.s;
    s8_nxt.remx   = mx[SW+QW-1:QW];
    s8_nxt.remy   = my[SW+QW-1:QW];
    s8_nxt.lox    = mx[QW-1:0];
    s8_nxt.loy    = my[QW-1:0];
    s8_nxt.px     = s7_r.px;
    s8_nxt.py     = s7_r.py;
    s8_nxt.dsq    = s7_r.dsq;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) v_r[0] <= in_valid;
      for (int k = 1; k < 8; k++) if (adv[k]) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) s1_r <= s1_nxt;
    if (adv[1]) s2_r <= s2_nxt;
    if (adv[2]) s3_r <= s3_nxt;
    if (adv[3]) s4_r <= s4_nxt;
    if (adv[4]) s5_r <= s5_nxt;
    if (adv[5]) s6_r <= s6_nxt;
    if (adv[6]) s7_r <= s7_nxt;
    if (adv[7]) s8_r <= s8_nxt;
  end

  assign dn_valid = v_r[7];
  assign dn_data  = s8_r;

endmodule

FILE: design/rsi_div_cell.sv
// Divider cell: one restoring quotient bit for x and for y
`timescale 1ns / 1ps
module rsi_div_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  input  rsi_pkg::rsi_div_t  up_data,
  output logic               up_adv,
  output logic               dn_valid,
  output rsi_pkg::rsi_div_t  dn_data,
  input  logic               dn_adv
);
  import rsi_pkg::*;

  logic     v_r;
  rsi_div_t d_r, d_nxt;

  assign up_adv = !v_r || dn_adv;

  always_comb begin
    logic [SW:0] rx, ry, sx;
    logic        gx, gy;
    sx = {1'b0, up_data.s};
    rx = {up_data.remx, up_data.lox[QW-1]};
    ry = {up_data.remy, up_data.loy[QW-1]};
    gx = rx >= sx;
    gy = ry >= sx;
    d_nxt      = up_data;
    d_nxt.remx = gx ? SW'(rx - sx) : rx[SW-1:0];
    d_nxt.remy = gy ? SW'(ry - sx) : ry[SW-1:0];
    d_nxt.lox  = {up_data.lox[QW-2:0], gx};
    d_nxt.loy  = {up_data.loy[QW-2:0], gy};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_adv) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_adv) d_r <= d_nxt;
  end

  assign dn_valid = v_r;
  assign dn_data  = d_r;

endmodule

FILE: design/rsi_back.sv
// Back pipeline: sign of quotient, reach test and output register
`timescale 1ns / 1ps
module rsi_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  input  rsi_pkg::rsi_div_t  up_data,
  output logic               up_adv,
  output logic               out_valid,
  input  logic               out_stall,
  output rsi_pkg::rsi_out_t  out_data
);
  import rsi_pkg::*;

  typedef struct packed {
    logic                 online, nohit;
    logic signed [CW-1:0] ix, iy, px, py;
    logic signed [CW:0]   ex, ey;
    logic [DQW-1:0]       dsq;
  } bk1_t;

  typedef struct packed {
    logic                 online, nohit;
    logic signed [CW-1:0] ix, iy, px, py;
    logic [2*CW+1:0]      exx, eyy;
    logic [DQW-1:0]       dsq;
  } bk2_t;

  logic     v1_r, v2_r, ov_r;
  logic     a1, a2, ao;
  bk1_t     b1_r, b1_nxt;
  bk2_t     b2_r, b2_nxt;
  rsi_out_t o_r, o_nxt;

  assign ao     = !ov_r || !out_stall;
  assign a2     = !v2_r || ao;
  assign a1     = !v1_r || a2;
  assign up_adv = a1;

  always_comb begin
    logic [CW-1:0] ix, iy;
    ix = up_data.negx ? (CW'(0) - up_data.lox) : up_data.lox;
    iy = up_data.negy ? (CW'(0) - up_data.loy) : up_data.loy;
    b1_nxt.online = up_data.online;
    b1_nxt.nohit  = up_data.nohit;
    b1_nxt.ix     = ix;
    b1_nxt.iy     = iy;
    b1_nxt.px     = up_data.px;
    b1_nxt.py     = up_data.py;
    b1_nxt.ex     = {ix[CW-1], ix} - {up_data.px[CW-1], up_data.px};
    b1_nxt.ey     = {iy[CW-1], iy} - {up_data.py[CW-1], up_data.py};
    b1_nxt.dsq    = up_data.dsq;
  end

  always_comb begin
    logic signed [2*CW+1:0] qx, qy;
    qx = b1_r.ex * b1_r.ex;
    qy = b1_r.ey * b1_r.ey;
    b2_nxt.online = b1_r.online;
    b2_nxt.nohit  = b1_r.nohit;
    b2_nxt.ix     = b1_r.ix;
    b2_nxt.iy     = b1_r.iy;
    b2_nxt.px     = b1_r.px;
    b2_nxt.py     = b1_r.py;
    b2_nxt.exx    = qx;
    b2_nxt.eyy    = qy;
    b2_nxt.dsq    = b1_r.dsq;
  end

  always_comb begin
    logic [2*CW+2:0] esq;
    logic            reach;
    esq   = {1'b0, b2_r.exx} + {1'b0, b2_r.eyy};
    reach = !({(2*CW+3-DQW)'(0), b2_r.dsq} < esq);
    o_nxt.on_segment_line = b2_r.online;
    if (b2_r.online) begin
      o_nxt.hit   = 1'b1;
      o_nxt.int_x = b2_r.px;
      o_nxt.int_y = b2_r.py;
    end else if (!b2_r.nohit && reach) begin
      o_nxt.hit   = 1'b1;
      o_nxt.int_x = b2_r.ix;
      o_nxt.int_y = b2_r.iy;
    end else begin
      o_nxt.hit   = 1'b0;
      o_nxt.int_x = '0;
      o_nxt.int_y = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (a1) v1_r <= up_valid;
      if (a2) v2_r <= v1_r;
      if (ao) ov_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a1) b1_r <= b1_nxt;
    if (a2) b2_r <= b2_nxt;
    if (ao) o_r  <= o_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = o_r;

endmodule

FILE: design/ray_segment_intersect.sv
// Top level: ray step against 2D segment, fixed point, fully pipelined
// Takes one query per cycle while the input is not stalled and returns one result per query,
// in order, through 8 front stages (offsets, cross products, weights, numerators), a row of
// 32 divider cells each settling one quotient bit of x and y, two back stages for the reach
// test, then the output register. Stalls let bubbles close up, so the input keeps taking
// transfers while empty stages remain.
`timescale 1ns / 1ps
module ray_segment_intersect (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  rsi_pkg::rsi_in_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rsi_pkg::rsi_out_t  out_data
);
  import rsi_pkg::*;

  logic [31:0] thr_r;
  logic        cv [QW+1];
  rsi_div_t    cd [QW+1];
  logic        ca [QW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  rsi_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .thr      (thr_r),
    .dn_valid (cv[0]),
    .dn_data  (cd[0]),
    .dn_adv   (ca[0])
  );

  for (genvar k = 0; k < QW; k++) begin : g_cell
    rsi_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (cv[k]),
      .up_data  (cd[k]),
      .up_adv   (ca[k]),
      .dn_valid (cv[k+1]),
      .dn_data  (cd[k+1]),
      .dn_adv   (ca[k+1])
    );
  end

  rsi_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (cv[QW]),
    .up_data   (cd[QW]),
    .up_adv    (ca[QW]),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_online_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.on_segment_line |-> out_data.hit)
    else $error("on-line result without hit");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> out_data.int_x == '0 && out_data.int_y == '0)
    else $error("miss with non-zero point");

  a_free_accept: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output register");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule
